// ===== sv/bsv_pkg.sv =====
// Shared types and constants of the BMP 24-bit stream validator.
// No dependencies; every other file but bsv_mul and the testbench top refers to this package by scoped names.
package bsv_pkg;

  // Default coordinate width and queue depth
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Fixed header constants
  localparam logic [31:0] MIN_FILE_LEN = 32'd58;
  localparam logic [31:0] PIXEL_OFFSET = 32'd54;
  localparam logic [31:0] INFO_HDR_LEN = 32'd40;
  localparam logic [15:0] BITS_PER_PIX = 16'd24;
  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [5:0]  POS_FILE_END = 6'd13;
  localparam logic [5:0]  POS_HGT_END  = 6'd25;
  localparam logic [5:0]  POS_INFO_END = 6'd53;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_HDR   = 2'd1;
  localparam logic [1:0] ST_BAD_PAD   = 2'd2;
  localparam logic [1:0] ST_EARLY_END = 2'd3;

  // One queue entry: the results caused by one accepted byte
  typedef struct packed {
    logic        has_pix;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] row;
    logic [15:0] col;
    logic        has_st;
    logic [1:0]  st;
  } bsv_entry_t;

endpackage

// ===== sv/bsv_mul.sv =====
// Iterative multiplier for the image size check, two multiplier bits per cycle.
// Depends on nothing outside this file.
module bsv_mul #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COORD_BITS-1:0]   height_i,
  input  logic [COORD_BITS+1:0]   row_bytes_i,
  output logic [2*COORD_BITS+1:0] prod_o
);

  localparam int unsigned PW = 2 * COORD_BITS + 2;

  logic [COORD_BITS-1:0] h_q, h_d;
  logic [PW-1:0]         m_q, m_d;
  logic [PW-1:0]         acc_q, acc_d;

  // Load on start, then add shifted partial products until the height runs out
  always_comb begin
    h_d   = h_q;
    m_d   = m_q;
    acc_d = acc_q;
    if (start_i) begin
      h_d   = height_i;
      m_d   = PW'(row_bytes_i);
      acc_d = '0;
    end else if (h_q != '0) begin
      acc_d = acc_q + (h_q[0] ? m_q : '0) + (h_q[1] ? (m_q << 1) : '0);
      m_d   = m_q << 2;
      h_d   = h_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else begin
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;

endmodule

// ===== sv/bsv_front.sv =====
// Front end: byte parser that checks the headers and classifies each byte.
// Depends on bsv_pkg and bsv_mul; pushes one entry per byte with results.
module bsv_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                acc_i,
  input  logic [7:0]          byte_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic                push_o,
  output bsv_pkg::bsv_entry_t ent_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_PIX  = 2'd2;
  localparam logic [1:0] PH_PAD  = 2'd3;
  localparam int unsigned PW = 2 * COORD_BITS + 2;

  logic [31:0] flen_q;
  logic [1:0]  phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic        sig_q, sig_d, res_q, res_d, stop_q, stop_d, fault_q, fault_d;
  logic [31:0] decl_q, decl_d, offs_q, offs_d, info_q, info_d;
  logic [31:0] wid_q, wid_d, hgt_q, hgt_d;
  logic [15:0] planes_q, planes_d, depth_q, depth_d;
  logic [COORD_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]  comp_q, comp_d, padl_q, padl_d;
  logic [7:0]  hb_q, hb_d, hg_q, hg_d;

  logic [1:0]            pad;
  logic [COORD_BITS+1:0] row_bytes;
  logic [PW-1:0]         prod;
  logic [63:0]           size_calc;
  logic                  mul_start;
  bsv_pkg::bsv_entry_t   ent;

  // Pad bytes per row and bytes per row, from the captured width
  assign pad       = 2'(2'd0 - wid_q[1:0]);
  assign row_bytes = (COORD_BITS+2)'(wid_q[COORD_BITS-1:0])
                   + (COORD_BITS+2)'({wid_q[COORD_BITS-1:0], 1'b0})
                   + (COORD_BITS+2)'(pad);
  assign size_calc = 64'(prod) + 64'(bsv_pkg::PIXEL_OFFSET);

  bsv_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_start),
    .height_i   (hgt_d[COORD_BITS-1:0]),
    .row_bytes_i(row_bytes),
    .prod_o     (prod)
  );

  // Parse one accepted byte
  always_comb begin
    logic [1:0] lane;
    logic       hdr_ok;
    logic       info_ok;
    phase_d  = phase_q;  pos_d    = pos_q;    sig_d  = sig_q;  res_d = res_q;
    stop_d   = stop_q;   fault_d  = fault_q;  decl_d = decl_q; offs_d = offs_q;
    info_d   = info_q;   wid_d    = wid_q;    hgt_d  = hgt_q;
    planes_d = planes_q; depth_d  = depth_q;  row_d  = row_q;  col_d = col_q;
    comp_d   = comp_q;   padl_d   = padl_q;   hb_d   = hb_q;   hg_d  = hg_q;
    ent       = '0;
    mul_start = 1'b0;
    lane      = 2'(pos_q[1:0] + 2'd2);
    hdr_ok    = 1'b0;
    info_ok   = 1'b0;
    if (acc_i) begin
      // Restart on the first byte of a file
      if (first_i) begin
        phase_d = PH_HEAD; pos_d = '0; sig_d = 1'b0; res_d = 1'b0;
        stop_d = 1'b0; fault_d = 1'b0; decl_d = '0; offs_d = '0; info_d = '0;
        wid_d = '0; hgt_d = '0; planes_d = '0; depth_d = '0; row_d = '0;
        col_d = '0; comp_d = '0; padl_d = '0; hb_d = '0; hg_d = '0;
        lane = 2'd2;
        if (flen_q < bsv_pkg::MIN_FILE_LEN) begin
          ent.has_st = 1'b1; ent.st = bsv_pkg::ST_BAD_HDR;
          stop_d = 1'b1; phase_d = PH_IDLE;
        end
      end
      if (!stop_d && phase_d != PH_IDLE) begin
        unique case (phase_d)
          PH_HEAD: begin
            // Capture header fields, little endian
            if (pos_d == 6'd0) sig_d = (byte_i == bsv_pkg::SIG_B);
            else if (pos_d == 6'd1) sig_d = sig_d && (byte_i == bsv_pkg::SIG_M);
            else if (pos_d < 6'd6) decl_d[lane*8 +: 8] = byte_i;
            else if (pos_d < 6'd10) res_d = ((pos_d == 6'd6) ? 1'b1 : res_d) && (byte_i == 8'd0);
            else if (pos_d < 6'd14) offs_d[lane*8 +: 8] = byte_i;
            else if (pos_d < 6'd18) info_d[lane*8 +: 8] = byte_i;
            else if (pos_d < 6'd22) wid_d[lane*8 +: 8] = byte_i;
            else if (pos_d < 6'd26) hgt_d[lane*8 +: 8] = byte_i;
            else if (pos_d < 6'd28) planes_d[lane[0]*8 +: 8] = byte_i;
            else if (pos_d < 6'd30) depth_d[pos_d[0]*8 +: 8] = byte_i;
            mul_start = (pos_d == bsv_pkg::POS_HGT_END);
            hdr_ok = sig_d && (decl_d == flen_q) && res_d
                  && (offs_d == bsv_pkg::PIXEL_OFFSET);
            info_ok = (info_d == bsv_pkg::INFO_HDR_LEN) && (planes_d == 16'd1)
                   && (depth_d == bsv_pkg::BITS_PER_PIX)
                   && (wid_d[31:COORD_BITS] == '0) && (hgt_d[31:COORD_BITS] == '0)
                   && (size_calc == {32'd0, decl_d});
            if (pos_d == bsv_pkg::POS_FILE_END && !hdr_ok) begin
              ent.has_st = 1'b1; ent.st = bsv_pkg::ST_BAD_HDR;
              stop_d = 1'b1; phase_d = PH_IDLE;
            end else if (pos_d == bsv_pkg::POS_INFO_END) begin
              if (!info_ok) begin
                ent.has_st = 1'b1; ent.st = bsv_pkg::ST_BAD_HDR;
                stop_d = 1'b1; phase_d = PH_IDLE;
              end else begin
                phase_d = PH_PIX; row_d = '0; col_d = '0; comp_d = '0;
                if (wid_d == '0 || hgt_d == '0) begin
                  ent.has_st = 1'b1; ent.st = bsv_pkg::ST_OK;
                  stop_d = 1'b1; phase_d = PH_IDLE;
                end
              end
            end else begin
              pos_d = pos_d + 6'd1;
            end
          end
          PH_PIX: begin
            // Collect blue, green, red and emit the pixel
            if (comp_d == 2'd0) begin
              hb_d = byte_i; comp_d = 2'd1;
            end else if (comp_d == 2'd1) begin
              hg_d = byte_i; comp_d = 2'd2;
            end else begin
              ent.has_pix = 1'b1; ent.blue = hb_d; ent.green = hg_d;
              ent.red = byte_i; ent.row = 16'(row_d); ent.col = 16'(col_d);
              comp_d = 2'd0;
              col_d = col_d + COORD_BITS'(1);
              if (col_d >= wid_d[COORD_BITS-1:0]) begin
                if (pad != 2'd0) begin
                  phase_d = PH_PAD; padl_d = pad; fault_d = 1'b0;
                end else begin
                  row_d = row_d + COORD_BITS'(1); col_d = '0;
                  if (row_d >= hgt_d[COORD_BITS-1:0]) begin
                    ent.has_st = 1'b1; ent.st = bsv_pkg::ST_OK;
                    stop_d = 1'b1; phase_d = PH_IDLE;
                  end
                end
              end
            end
          end
          PH_PAD: begin
            // Check pad bytes and advance to the next row
            if (byte_i != 8'd0) fault_d = 1'b1;
            padl_d = padl_d - 2'd1;
            if (padl_d == 2'd0) begin
              if (fault_d) begin
                ent.has_st = 1'b1; ent.st = bsv_pkg::ST_BAD_PAD;
                stop_d = 1'b1; phase_d = PH_IDLE;
              end else begin
                row_d = row_d + COORD_BITS'(1); col_d = '0; phase_d = PH_PIX;
                if (row_d >= hgt_d[COORD_BITS-1:0]) begin
                  ent.has_st = 1'b1; ent.st = bsv_pkg::ST_OK;
                  stop_d = 1'b1; phase_d = PH_IDLE;
                end
              end
            end
          end
          default: ;
        endcase
        // Stream ended before the parse completed
        if (!stop_d && last_i) begin
          ent.has_st = 1'b1; ent.st = bsv_pkg::ST_EARLY_END;
          stop_d = 1'b1; phase_d = PH_IDLE;
        end
      end
    end
  end

  assign push_o = ent.has_pix | ent.has_st;
  assign ent_o  = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= '0; phase_q <= PH_IDLE; pos_q <= '0; sig_q <= 1'b0;
      res_q <= 1'b0; stop_q <= 1'b0; fault_q <= 1'b0; decl_q <= '0;
      offs_q <= '0; info_q <= '0; wid_q <= '0; hgt_q <= '0; planes_q <= '0;
      depth_q <= '0; row_q <= '0; col_q <= '0; comp_q <= '0; padl_q <= '0;
      hb_q <= '0; hg_q <= '0;
    end else begin
      if (cfg_we_i) flen_q <= cfg_data_i;
      phase_q <= phase_d; pos_q <= pos_d; sig_q <= sig_d; res_q <= res_d;
      stop_q <= stop_d; fault_q <= fault_d; decl_q <= decl_d; offs_q <= offs_d;
      info_q <= info_d; wid_q <= wid_d; hgt_q <= hgt_d; planes_q <= planes_d;
      depth_q <= depth_d; row_q <= row_d; col_q <= col_d; comp_q <= comp_d;
      padl_q <= padl_d; hb_q <= hb_d; hg_q <= hg_d;
    end
  end

endmodule

// ===== sv/bsv_queue.sv =====
// Short queue of result entries between the parser and the output stage.
// Depends on bsv_pkg for the entry type.
module bsv_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  bsv_pkg::bsv_entry_t wdata_i,
  input  logic                rd_i,
  output bsv_pkg::bsv_entry_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bsv_pkg::bsv_entry_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (rd_i && !empty_o) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + CW'(wr_i && !full_o) - CW'(rd_i && !empty_o);
    end
  end

endmodule

// ===== sv/bsv_back.sv =====
// Back end: expands each queued entry into one or two result transactions.
// Depends on bsv_pkg for the entry type and status codes.
module bsv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsv_pkg::bsv_entry_t ent_i,
  input  logic                q_empty_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic                kind_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          green_o,
  output logic [7:0]          red_o,
  output logic [15:0]         pixel_row_o,
  output logic [15:0]         pixel_column_o,
  output logic [1:0]          status_o,
  output logic                last_of_run_o
);

  logic pix_done_q, pix_done_d;
  logic show_pix, take;

  assign show_pix = ent_i.has_pix && !pix_done_q;
  assign take     = pop_i && !q_empty_i;
  assign q_rd_o   = take && !(show_pix && ent_i.has_st);

  // Remember that the pixel half of a two-result entry has gone out
  always_comb begin
    pix_done_d = pix_done_q;
    if (take) pix_done_d = show_pix && ent_i.has_st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pix_done_q <= 1'b0;
    else         pix_done_q <= pix_done_d;
  end

  assign empty_o        = q_empty_i;
  assign kind_o         = !show_pix;
  assign blue_o         = show_pix ? ent_i.blue  : 8'd0;
  assign green_o        = show_pix ? ent_i.green : 8'd0;
  assign red_o          = show_pix ? ent_i.red   : 8'd0;
  assign pixel_row_o    = show_pix ? ent_i.row   : 16'd0;
  assign pixel_column_o = show_pix ? ent_i.col   : 16'd0;
  assign status_o       = show_pix ? bsv_pkg::ST_OK : ent_i.st;
  assign last_of_run_o  = !show_pix;

endmodule

// ===== sv/bmp_24bit_stream_validator_core.sv =====
// Top level of the BMP 24-bit stream validator: parser, queue and output stage.
// Depends on bsv_pkg, bsv_mul, bsv_front, bsv_queue and bsv_back.
//
//   channel   handshake                 payload
//   input     push / full               data_byte_i, first_of_file_i, last_of_file_i
//   result    pop / empty               kind_o .. last_of_run_o
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (file_length)
//
// One byte per cycle is accepted while full is low; a byte's entry enters the queue on the same edge.
// One result leaves per cycle while empty is low; a byte with a pixel and a status takes two pops.
// The size check multiplier starts on the last height byte and is done well inside
// the 28 bytes that still come before the size check.
// full rises only when the queue holds QUEUE_DEPTH entries. Reset clears all control.
module bmp_24bit_stream_validator_core #(
  parameter int unsigned COORD_BITS  = bsv_pkg::COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = bsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_file_i,
  input  logic        last_of_file_i,
  input  logic        pop,
  output logic        empty,
  output logic        kind_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_column_o,
  output logic [1:0]  status_o,
  output logic        last_of_run_o
);

  logic                q_wr, q_rd, q_empty;
  bsv_pkg::bsv_entry_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  bsv_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .acc_i     (push && !full),
    .byte_i    (data_byte_i),
    .first_i   (first_of_file_i),
    .last_i    (last_of_file_i),
    .push_o    (q_wr),
    .ent_o     (q_wdata)
  );

  bsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .wdata_i(q_wdata),
    .rd_i   (q_rd),
    .rdata_o(q_rdata),
    .full_o (full),
    .empty_o(q_empty)
  );

  bsv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ent_i         (q_rdata),
    .q_empty_i     (q_empty),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .kind_o        (kind_o),
    .blue_o        (blue_o),
    .green_o       (green_o),
    .red_o         (red_o),
    .pixel_row_o   (pixel_row_o),
    .pixel_column_o(pixel_column_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== tb/bmp_24bit_stream_validator_core_checker.sv =====
// Checker for the BMP 24-bit stream validator: watches the byte, config and result
// channels, predicts the results of each byte and compares them. Depends on bsv_pkg.
`timescale 1ns / 1ps
module bmp_24bit_stream_validator_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_file_i,
  input  logic        last_of_file_i,
  input  logic        pop,
  input  logic        empty,
  input  logic        kind_o,
  input  logic [7:0]  blue_o,
  input  logic [7:0]  green_o,
  input  logic [7:0]  red_o,
  input  logic [15:0] pixel_row_o,
  input  logic [15:0] pixel_column_o,
  input  logic [1:0]  status_o,
  input  logic        last_of_run_o,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] row;
    logic [15:0] col;
    logic [1:0]  st;
    logic        last;
  } bmp_result_t;

  typedef enum logic [1:0] {P_IDLE, P_HEAD, P_PIX, P_PAD} parse_phase_e;

  localparam logic [31:0] DIM_MAX = 32'((64'd1 << bsv_pkg::COORD_BITS_DEF) - 64'd1);

  bmp_result_t  result_q[$];
  logic [31:0]  len_reg;
  parse_phase_e phase;
  logic [5:0]   pos;
  logic         sig_ok, rsv_ok, halted, pad_bad;
  logic [31:0]  decl_size, offset, info_len, width, height;
  logic [15:0]  planes, depth;
  logic [31:0]  row, col;
  logic [1:0]   comp, pad_cnt;
  logic [7:0]   hold_b, hold_g;

  assign pending_count = result_q.size();

  function automatic logic [1:0] pad_of(logic [31:0] w);
    return 2'(3'd4 - {1'b0, w[1:0]});
  endfunction

  // Queue a status result and halt parsing of this file
  task automatic end_file(logic [1:0] st);
    bmp_result_t r;
    r = '0;
    r.kind = 1'b1;
    r.st = st;
    r.last = 1'b1;
    result_q.push_back(r);
    halted = 1'b1;
    phase = P_IDLE;
  endtask

  task automatic advance_row();
    row = row + 1;
    col = 0;
    phase = P_PIX;
    if (row >= height) end_file(bsv_pkg::ST_OK);
  endtask

  task automatic clear_parse();
    phase = P_IDLE; pos = '0; sig_ok = 0; rsv_ok = 0; halted = 0; pad_bad = 0;
    decl_size = '0; offset = '0; info_len = '0; width = '0; height = '0;
    planes = '0; depth = '0; row = '0; col = '0; comp = '0; pad_cnt = '0;
    hold_b = '0; hold_g = '0;
  endtask

  // Predict the results of one accepted byte
  task automatic predict_byte(logic [7:0] b, logic first, logic last);
    bmp_result_t r;
    logic [63:0] sz;
    logic        info_good;
    if (first) begin
      clear_parse();
      phase = P_HEAD;
      if (len_reg < bsv_pkg::MIN_FILE_LEN) begin
        end_file(bsv_pkg::ST_BAD_HDR);
        return;
      end
    end
    if (halted || phase == P_IDLE) return;
    case (phase)
      P_HEAD: begin
        if (pos == 0) sig_ok = (b == bsv_pkg::SIG_B);
        else if (pos == 1) sig_ok = sig_ok && (b == bsv_pkg::SIG_M);
        else if (pos < 6) decl_size[(pos - 2) * 8 +: 8] = b;
        else if (pos < 10) rsv_ok = (pos == 6 ? 1'b1 : rsv_ok) && (b == 0);
        else if (pos < 14) offset[(pos - 10) * 8 +: 8] = b;
        else if (pos < 18) info_len[(pos - 14) * 8 +: 8] = b;
        else if (pos < 22) width[(pos - 18) * 8 +: 8] = b;
        else if (pos < 26) height[(pos - 22) * 8 +: 8] = b;
        else if (pos < 28) planes[(pos - 26) * 8 +: 8] = b;
        else if (pos < 30) depth[(pos - 28) * 8 +: 8] = b;
        if (pos == bsv_pkg::POS_FILE_END &&
            !(sig_ok && decl_size == len_reg && rsv_ok &&
              offset == bsv_pkg::PIXEL_OFFSET)) begin
          end_file(bsv_pkg::ST_BAD_HDR);
          return;
        end
        if (pos == bsv_pkg::POS_INFO_END) begin
          info_good = info_len == bsv_pkg::INFO_HDR_LEN && planes == 16'd1 &&
                      depth == bsv_pkg::BITS_PER_PIX &&
                      width <= DIM_MAX && height <= DIM_MAX;
          sz = 64'(height) * (64'(width) * 3 + 64'(pad_of(width)))
             + 64'(bsv_pkg::PIXEL_OFFSET);
          if (!info_good || sz != 64'(decl_size)) begin
            end_file(bsv_pkg::ST_BAD_HDR);
            return;
          end
          phase = P_PIX; row = 0; col = 0; comp = 0;
          if (width == 0 || height == 0) end_file(bsv_pkg::ST_OK);
        end else begin
          pos = pos + 1;
        end
      end
      P_PIX: begin
        if (comp == 0) begin
          hold_b = b; comp = 1;
        end else if (comp == 1) begin
          hold_g = b; comp = 2;
        end else begin
          r = '0;
          r.blue = hold_b; r.green = hold_g; r.red = b;
          r.row = row[15:0]; r.col = col[15:0];
          result_q.push_back(r);
          comp = 0;
          col = col + 1;
          if (col >= width) begin
            if (pad_of(width) != 0) begin
              phase = P_PAD; pad_cnt = pad_of(width); pad_bad = 0;
            end else begin
              advance_row();
            end
          end
        end
      end
      P_PAD: begin
        if (b != 0) pad_bad = 1;
        pad_cnt = pad_cnt - 1;
        if (pad_cnt == 0) begin
          if (pad_bad) end_file(bsv_pkg::ST_BAD_PAD);
          else advance_row();
        end
      end
      default: ;
    endcase
    if (!halted && last) end_file(bsv_pkg::ST_EARLY_END);
  endtask

  // Sample all channels at the clock edge and update the prediction
  always @(posedge clk_i or negedge rst_ni) begin
    bmp_result_t got, want;
    if (!rst_ni) begin
      len_reg = '0;
      clear_parse();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) len_reg = cfg_data_i;
      if (pop && !empty) begin
        got = {kind_o, blue_o, green_o, red_o, pixel_row_o, pixel_column_o,
               status_o, last_of_run_o};
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: unexpected result %h", got);
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: exp kind=%0d bgr=%h/%h/%h row=%0d col=%0d st=%0d last=%0d",
                       want.kind, want.blue, want.green, want.red, want.row, want.col,
                       want.st, want.last);
              $display("       got kind=%0d bgr=%h/%h/%h row=%0d col=%0d st=%0d last=%0d",
                       got.kind, got.blue, got.green, got.red, got.row, got.col,
                       got.st, got.last);
            end
          end
        end
      end
      if (push && !full) predict_byte(data_byte_i, first_of_file_i, last_of_file_i);
    end
  end
endmodule

// ===== tb/bmp_24bit_stream_validator_core_tb.sv =====
// Testbench top for the BMP 24-bit stream validator: builds BMP files, streams them
// with random gaps and stalls, and reports the verdict. Depends on the validator core and the checker.
`timescale 1ns / 1ps
module bmp_24bit_stream_validator_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_valid_i = 0, cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        push = 0, full;
  logic [7:0]  data_byte_i = '0;
  logic        first_of_file_i = 0, last_of_file_i = 0;
  logic        pop = 0, empty;
  logic        kind_o, last_of_run_o;
  logic [7:0]  blue_o, green_o, red_o;
  logic [15:0] pixel_row_o, pixel_column_o;
  logic [1:0]  status_o;
  int          fail_count, pending_count;
  int          idle_cycles = 0;
  bit          allow_stall = 1;
  int          byte_total = 0;

  bmp_24bit_stream_validator_core u_top (.*);
  bmp_24bit_stream_validator_core_checker u_chk (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // Drain side: pop with random stall bursts
  always @(posedge clk_i) begin
    int stall;
    if (allow_stall && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 3);
      pop <= 0;
      repeat (stall) @(posedge clk_i);
    end
    pop <= 1;
  end

  // Stall watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bmp_24bit_stream_validator_core_tb: done, errors");
      $finish;
    end
  end

  // Push one byte, holding it until accepted
  task automatic send_byte(logic [7:0] b, logic first, logic last);
    if (allow_stall && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push <= 1;
    data_byte_i <= b;
    first_of_file_i <= first;
    last_of_file_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    byte_total++;
  endtask

  // Wait for all results plus the multiplier latency, then write file_length
  task automatic set_length(logic [31:0] len);
    push <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Stream one file; mode 0 well formed, 1 random header fault, 2 truncate, 3 bad pad,
  // 4 stop after the first 60 bytes
  task automatic send_file(int w, int h, int mode, logic [31:0] len_override, bit use_ovr);
    logic [7:0]  img[$];
    logic [31:0] sz, v;
    int          pad, cut, k;
    pad = (4 - (w % 4)) % 4;
    sz = h * (3 * w + pad) + 54;
    img = '{8'h42, 8'h4D};
    for (k = 0; k < 4; k++) img.push_back(sz[8 * k +: 8]);
    repeat (4) img.push_back(8'h00);
    v = 54; for (k = 0; k < 4; k++) img.push_back(v[8 * k +: 8]);
    v = 40; for (k = 0; k < 4; k++) img.push_back(v[8 * k +: 8]);
    v = w;  for (k = 0; k < 4; k++) img.push_back(v[8 * k +: 8]);
    v = h;  for (k = 0; k < 4; k++) img.push_back(v[8 * k +: 8]);
    img.push_back(8'd1); img.push_back(8'd0); img.push_back(8'd24); img.push_back(8'd0);
    repeat (24) img.push_back(8'($urandom_range(0, 255)));
    for (int r = 0; r < h; r++) begin
      repeat (3 * w) img.push_back(8'($urandom_range(0, 255)));
      repeat (pad) img.push_back((mode == 3 && $urandom_range(0, 2) == 0) ?
                                 8'($urandom_range(1, 255)) : 8'h00);
    end
    if (mode == 1) begin
      k = $urandom_range(0, 29);
      img[k] = img[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    set_length(use_ovr ? len_override : sz);
    if (mode == 2) cut = $urandom_range(1, img.size());
    else if (mode == 4 && img.size() > 60) cut = 60;
    else cut = img.size();
    for (k = 0; k < cut; k++) send_byte(img[k], k == 0, k == cut - 1);
    if ($urandom_range(0, 3) == 0)
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: bytes before any file start, short files, extremes
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    set_length(32'd0);
    send_byte(8'h42, 1'b1, 1'b0);
    send_byte(8'h4D, 1'b0, 1'b1);
    set_length(32'd57);
    send_byte(8'hFF, 1'b1, 1'b1);
    set_length(32'hFFFF_FFFF);
    send_byte(8'h42, 1'b1, 1'b0);
    send_file(0, 3, 0, 0, 0);
    send_file(2, 0, 0, 0, 0);
    send_file(1, 1, 0, 0, 0);
    send_file(3, 2, 3, 0, 0);
    send_file(4, 2, 0, 0, 0);
    send_file(5, 1, 2, 0, 0);
    send_file(1, 1, 0, 32'd100, 1);
    send_file(70000, 1, 4, 0, 0);
    send_file(1, 32'hFFFF_FFFF, 0, 0, 0);
    // Random files, mostly well formed; no random stalls in the last part
    while (byte_total < 600) begin
      int m;
      if (byte_total > 480) allow_stall = 0;
      m = $urandom_range(0, 9);
      send_file($urandom_range(1, 6), $urandom_range(1, 4),
                m < 6 ? 0 : (m == 6 ? 1 : (m == 7 ? 2 : 3)), 0, 0);
    end
    push <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) $display("bmp_24bit_stream_validator_core_tb: done, clean");
    else $display("bmp_24bit_stream_validator_core_tb: done, errors");
    $finish;
  end
endmodule
